// ===== design/gepq_pkg.sv =====
// Shared constants, codes and helper functions of the gossip event queue.
package gepq_pkg;

    localparam int SIZE_W   = 32;
    localparam int INC_W    = 64;
    localparam int CNT_W    = 16;
    localparam int MULT_W   = 8;
    localparam int ST_W     = 2;
    localparam int RC_W     = 2;
    localparam int BUDGET_W = 5;
    localparam int LEFT_W   = 7;
    localparam int LIMIT_W  = 7;
    localparam int THR_W    = 15;
    localparam int BITS_W   = $clog2(SIZE_W + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_PACK    = 1'b1;

    localparam logic [RC_W-1:0] RC_OK      = 2'd0;
    localparam logic [RC_W-1:0] RC_INVALID = 2'd1;
    localparam logic [RC_W-1:0] RC_FULL    = 2'd2;

    localparam logic [ST_W-1:0] ST_ALIVE   = 2'd0;
    localparam logic [ST_W-1:0] ST_SUSPECT = 2'd1;
    localparam logic [ST_W-1:0] ST_DEAD    = 2'd2;

    // lower value goes out first
    function automatic logic [1:0] prio_of(input logic [ST_W-1:0] st);
        logic [1:0] p;
        case (st)
            ST_DEAD:    p = 2'd0;
            ST_SUSPECT: p = 2'd1;
            default:    p = 2'd2;
        endcase
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ===== design/gepq_ifs.sv =====
// Request and response channel interfaces of the gossip event queue.
interface gepq_req_if import gepq_pkg::*; #(
    parameter int ID_W = 32
);
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ID_W-1:0]     node_id;
    logic [ST_W-1:0]     status;
    logic [INC_W-1:0]    incarnation;
    logic [MULT_W-1:0]   multiplier;
    logic [SIZE_W-1:0]   group_size;
    logic [BUDGET_W-1:0] slot_budget;

    modport source (output valid, operation, node_id, status, incarnation, multiplier,
                    group_size, slot_budget, input ready);
    modport sink   (input valid, operation, node_id, status, incarnation, multiplier,
                    group_size, slot_budget, output ready);
endinterface

interface gepq_rsp_if import gepq_pkg::*; #(
    parameter int ID_W = 32
);
    logic              valid;
    logic              ready;
    logic [RC_W-1:0]   result_code;
    logic              has_event;
    logic [ID_W-1:0]   event_node;
    logic [ST_W-1:0]   event_status;
    logic [INC_W-1:0]  event_incarnation;
    logic              is_last;
    logic [LEFT_W-1:0] entries_left;

    modport source (output valid, result_code, has_event, event_node, event_status,
                    event_incarnation, is_last, entries_left, input ready);
    modport sink   (input valid, result_code, has_event, event_node, event_status,
                    event_incarnation, is_last, entries_left, output ready);
endinterface

// ===== design/gossip_event_priority_queue.sv =====
// Gossip event queue: membership event table with ordered, pruning pack.
//
// Usage: requests enter on i_req (valid/ready), results leave on o_rsp
// (valid/ready). A beat is taken when valid and ready are both high.
// One request is worked on at a time; i_req.ready is high only while the
// block is idle and its result register is empty.
// Enqueue: the table is scanned through its single memory read port, one
// entry a cycle, and one result follows. Pack: the cluster size is
// bit-length encoded one bit a cycle, then each of the b = min(budget,
// MAX_PACKED, used) events is found by a full scan with the key
// comparator. The events are then sent one beat each, each held until the
// receiver takes it, and a compaction sweep follows if any event was
// pruned. An empty table or zero budget gives one eventless beat.
// A stalled receiver simply holds the block in its current output state.
// Reset empties the table at once (entry count to zero); no sweep needed.
module gossip_event_priority_queue import gepq_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_PACKED  = 16,
    parameter int ID_BITS     = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gepq_req_if.sink   i_req,
    gepq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = (MAX_PACKED > 1) ? $clog2(MAX_PACKED) : 1;
    localparam int BW = $clog2(MAX_PACKED + 1);
    localparam int CW = (UW > 7) ? UW : 7;
    localparam int KW = 2 + CNT_W + ID_BITS;

    typedef struct packed {
        logic [ID_BITS-1:0] node;
        logic [ST_W-1:0]    status;
        logic [INC_W-1:0]   inc;
        logic [CNT_W-1:0]   cnt;
        logic [MULT_W-1:0]  mult;
        logic               prune;
    } t_slot;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ENQ   = 10'b0000000010,
        S_LIM   = 10'b0000000100,
        S_SEL   = 10'b0000001000,
        S_EIDX  = 10'b0000010000,
        S_ERD   = 10'b0000100000,
        S_ELD   = 10'b0001000000,
        S_EWAIT = 10'b0010000000,
        S_CMP   = 10'b0100000000,
        S_RSP   = 10'b1000000000
    } t_state;

    function automatic logic [KW-1:0] key_of(input t_slot s);
        return {prio_of(s.status), s.cnt, s.node};
    endfunction

    // control
    t_state            r_state, n_state;
    logic [UW-1:0]     r_scan, n_scan;
    logic              r_pend, n_pend;
    logic [UW-1:0]     r_used, n_used;
    logic [UW-1:0]     r_wptr, n_wptr;
    logic [BW-1:0]     r_budget, n_budget;
    logic [BW-1:0]     r_round, n_round;
    logic [BW-1:0]     r_removed, n_removed;
    logic              r_first, n_first;
    logic              r_have, n_have;
    logic              r_o_valid, n_o_valid;

    // payload
    logic [ID_BITS-1:0] r_node, n_node;
    logic [ST_W-1:0]    r_status, n_status;
    logic [INC_W-1:0]   r_inc, n_inc;
    logic [MULT_W-1:0]  r_mult, n_mult;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [KW-1:0]      r_last_key, n_last_key;
    logic [KW-1:0]      r_best_key, n_best_key;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic [MULT_W-1:0]  r_best_mult, n_best_mult;
    logic [CNT_W-1:0]   r_best_cnt, n_best_cnt;
    logic [RC_W-1:0]    r_o_code, n_o_code;
    logic               r_o_has, n_o_has;
    logic [ID_BITS-1:0] r_o_node, n_o_node;
    logic [ST_W-1:0]    r_o_status, n_o_status;
    logic [INC_W-1:0]   r_o_inc, n_o_inc;
    logic               r_o_last, n_o_last;
    logic [LEFT_W-1:0]  r_o_left, n_o_left;

    // storage
    t_slot              r_mem [TABLE_DEPTH];
    t_slot              r_rdata;
    logic [AW-1:0]      r_raddr;
    logic [AW-1:0]      r_pick [MAX_PACKED];
    logic [AW-1:0]      r_pick_q;

    logic               mem_re, mem_we, pick_we, pick_re;
    logic [AW-1:0]      mem_ra, mem_wa;
    t_slot              mem_wd;

    logic               scan_more, last_round, sel_hit;
    logic [MULT_W-1:0]  thr_mult;
    logic [THR_W-1:0]   thr;
    logic [CNT_W-1:0]   cnt_nx;
    logic [KW-1:0]      rd_key;
    logic [CW-1:0]      v_b;
    logic               upd_newer, upd_stronger;

    assign scan_more    = r_scan < r_used;
    assign last_round   = BW'(r_round + 1'b1) == r_budget;
    assign rd_key       = key_of(r_rdata);
    assign sel_hit      = (r_first || rd_key > r_last_key) && (!r_have || rd_key < r_best_key);
    // one threshold multiplier, shared between selection and write-back
    assign thr_mult     = (r_state == S_ELD) ? r_rdata.mult : r_best_mult;
    assign thr          = THR_W'(r_limit) * THR_W'(thr_mult);
    assign cnt_nx       = cnt_inc((r_state == S_ELD) ? r_rdata.cnt : r_best_cnt);
    assign upd_newer    = r_inc > r_rdata.inc;
    assign upd_stronger = (r_inc == r_rdata.inc) && (prio_of(r_status) < prio_of(r_rdata.status));

    assign i_req.ready           = (r_state == S_IDLE) && !r_o_valid;
    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.result_code     = r_o_code;
    assign o_rsp.has_event       = r_o_has;
    assign o_rsp.event_node      = r_o_node;
    assign o_rsp.event_status    = r_o_status;
    assign o_rsp.event_incarnation = r_o_inc;
    assign o_rsp.is_last         = r_o_last;
    assign o_rsp.entries_left    = r_o_left;

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_used      = r_used;
        n_wptr      = r_wptr;
        n_budget    = r_budget;
        n_round     = r_round;
        n_removed   = r_removed;
        n_first     = r_first;
        n_have      = r_have;
        n_o_valid   = r_o_valid;
        n_node      = r_node;
        n_status    = r_status;
        n_inc       = r_inc;
        n_mult      = r_mult;
        n_size      = r_size;
        n_bits      = r_bits;
        n_limit     = r_limit;
        n_last_key  = r_last_key;
        n_best_key  = r_best_key;
        n_best_idx  = r_best_idx;
        n_best_mult = r_best_mult;
        n_best_cnt  = r_best_cnt;
        n_o_code    = r_o_code;
        n_o_has     = r_o_has;
        n_o_node    = r_o_node;
        n_o_status  = r_o_status;
        n_o_inc     = r_o_inc;
        n_o_last    = r_o_last;
        n_o_left    = r_o_left;
        mem_re      = 1'b0;
        mem_ra      = r_scan[AW-1:0];
        mem_we      = 1'b0;
        mem_wa      = r_raddr;
        mem_wd      = r_rdata;
        pick_we     = 1'b0;
        pick_re     = 1'b0;
        v_b         = '0;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && !r_o_valid) begin
                    n_node   = i_req.node_id;
                    n_status = (i_req.status inside {ST_ALIVE, ST_SUSPECT, ST_DEAD}) ?
                               i_req.status : ST_ALIVE;
                    n_inc    = i_req.incarnation;
                    n_mult   = i_req.multiplier;
                    n_size   = i_req.group_size;
                    n_bits   = '0;
                    n_scan   = '0;
                    n_pend   = 1'b0;
                    n_o_code = RC_OK;
                    n_o_has  = 1'b0;
                    n_o_node = '0;
                    n_o_status = ST_ALIVE;
                    n_o_inc  = '0;
                    n_o_last = 1'b1;
                    n_o_left = LEFT_W'(r_used);
                    if (i_req.operation == OP_ENQUEUE) begin
                        if (i_req.multiplier == '0) begin
                            n_o_code  = RC_INVALID;
                            n_o_valid = 1'b1;
                            n_state   = S_RSP;
                        end else begin
                            n_state = S_ENQ;
                        end
                    end else if (r_used == '0 || i_req.slot_budget == '0) begin
                        n_o_valid = 1'b1;
                        n_state   = S_RSP;
                    end else begin
                        v_b = CW'(i_req.slot_budget);
                        if (v_b > CW'(MAX_PACKED)) begin
                            v_b = CW'(MAX_PACKED);
                        end
                        if (v_b > CW'(r_used)) begin
                            v_b = CW'(r_used);
                        end
                        n_budget = BW'(v_b);
                        n_state  = S_LIM;
                    end
                end
            end
            S_ENQ: begin
                if (r_pend && r_rdata.node == r_node) begin
                    if (upd_newer || upd_stronger) begin
                        mem_we        = 1'b1;
                        mem_wa        = r_raddr;
                        mem_wd        = r_rdata;
                        mem_wd.status = r_status;
                        mem_wd.inc    = r_inc;
                        mem_wd.cnt    = '0;
                        mem_wd.prune  = 1'b0;
                        if (upd_newer || r_mult > r_rdata.mult) begin
                            mem_wd.mult = r_mult;
                        end
                    end
                    n_pend    = 1'b0;
                    n_o_valid = 1'b1;
                    n_state   = S_RSP;
                end else if (!scan_more && !r_pend) begin
                    if (r_used == UW'(TABLE_DEPTH)) begin
                        n_o_code = RC_FULL;
                    end else begin
                        mem_we       = 1'b1;
                        mem_wa       = r_used[AW-1:0];
                        mem_wd.node  = r_node;
                        mem_wd.status = r_status;
                        mem_wd.inc   = r_inc;
                        mem_wd.cnt   = '0;
                        mem_wd.mult  = r_mult;
                        mem_wd.prune = 1'b0;
                        n_used       = UW'(r_used + 1'b1);
                        n_o_left     = LEFT_W'(UW'(r_used + 1'b1));
                    end
                    n_o_valid = 1'b1;
                    n_state   = S_RSP;
                end else begin
                    n_pend = scan_more;
                    if (scan_more) begin
                        mem_re = 1'b1;
                        n_scan = UW'(r_scan + 1'b1);
                    end
                end
            end
            S_LIM: begin
                // bit length of the cluster size, one bit a cycle
                if (r_size != '0) begin
                    n_size = r_size >> 1;
                    n_bits = BITS_W'(r_bits + 1'b1);
                end else begin
                    n_limit   = (r_bits == '0) ? LIMIT_W'(1) :
                                LIMIT_W'({r_bits, 1'b0}) + LIMIT_W'(r_bits);
                    n_round   = '0;
                    n_removed = '0;
                    n_first   = 1'b1;
                    n_have    = 1'b0;
                    n_scan    = '0;
                    n_pend    = 1'b0;
                    n_state   = S_SEL;
                end
            end
            S_SEL: begin
                if (r_pend && sel_hit) begin
                    n_best_key  = rd_key;
                    n_best_idx  = r_raddr;
                    n_best_mult = r_rdata.mult;
                    n_best_cnt  = r_rdata.cnt;
                    n_have      = 1'b1;
                end
                if (!scan_more && !r_pend) begin
                    pick_we    = 1'b1;
                    if (cnt_nx >= CNT_W'(thr)) begin
                        n_removed = BW'(r_removed + 1'b1);
                    end
                    n_last_key = r_best_key;
                    n_first    = 1'b0;
                    n_have     = 1'b0;
                    n_scan     = '0;
                    if (last_round) begin
                        n_round = '0;
                        n_state = S_EIDX;
                    end else begin
                        n_round = BW'(r_round + 1'b1);
                    end
                end else begin
                    n_pend = scan_more;
                    if (scan_more) begin
                        mem_re = 1'b1;
                        n_scan = UW'(r_scan + 1'b1);
                    end
                end
            end
            S_EIDX: begin
                pick_re = 1'b1;
                n_state = S_ERD;
            end
            S_ERD: begin
                mem_re  = 1'b1;
                mem_ra  = r_pick_q;
                n_state = S_ELD;
            end
            S_ELD: begin
                mem_we       = 1'b1;
                mem_wa       = r_pick_q;
                mem_wd       = r_rdata;
                mem_wd.cnt   = cnt_nx;
                mem_wd.prune = cnt_nx >= CNT_W'(thr);
                n_o_code     = RC_OK;
                n_o_has      = 1'b1;
                n_o_node     = r_rdata.node;
                n_o_status   = r_rdata.status;
                n_o_inc      = r_rdata.inc;
                n_o_last     = last_round;
                n_o_left     = LEFT_W'(UW'(r_used - UW'(r_removed)));
                n_o_valid    = 1'b1;
                n_state      = S_EWAIT;
            end
            S_EWAIT: begin
                if (r_o_valid && o_rsp.ready) begin
                    if (!last_round) begin
                        n_round = BW'(r_round + 1'b1);
                        n_state = S_EIDX;
                    end else if (r_removed != '0) begin
                        n_scan  = '0;
                        n_pend  = 1'b0;
                        n_wptr  = '0;
                        n_state = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CMP: begin
                if (r_pend && !r_rdata.prune) begin
                    mem_we = 1'b1;
                    mem_wa = r_wptr[AW-1:0];
                    mem_wd = r_rdata;
                    n_wptr = UW'(r_wptr + 1'b1);
                end
                if (!scan_more && !r_pend) begin
                    n_used  = r_wptr;
                    n_state = S_IDLE;
                end else begin
                    n_pend = scan_more;
                    if (scan_more) begin
                        mem_re = 1'b1;
                        n_scan = UW'(r_scan + 1'b1);
                    end
                end
            end
            S_RSP: begin
                if (r_o_valid && o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scan    <= '0;
            r_pend    <= 1'b0;
            r_used    <= '0;
            r_wptr    <= '0;
            r_budget  <= '0;
            r_round   <= '0;
            r_removed <= '0;
            r_first   <= 1'b1;
            r_have    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_pend    <= n_pend;
            r_used    <= n_used;
            r_wptr    <= n_wptr;
            r_budget  <= n_budget;
            r_round   <= n_round;
            r_removed <= n_removed;
            r_first   <= n_first;
            r_have    <= n_have;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_status    <= n_status;
        r_inc       <= n_inc;
        r_mult      <= n_mult;
        r_size      <= n_size;
        r_bits      <= n_bits;
        r_limit     <= n_limit;
        r_last_key  <= n_last_key;
        r_best_key  <= n_best_key;
        r_best_idx  <= n_best_idx;
        r_best_mult <= n_best_mult;
        r_best_cnt  <= n_best_cnt;
        r_o_code    <= n_o_code;
        r_o_has     <= n_o_has;
        r_o_node    <= n_o_node;
        r_o_status  <= n_o_status;
        r_o_inc     <= n_o_inc;
        r_o_last    <= n_o_last;
        r_o_left    <= n_o_left;
    end

    // event table and pick list
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
            r_raddr <= mem_ra;
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (pick_we) begin
            r_pick[r_round[PW-1:0]] <= r_best_idx;
        end
        if (pick_re) begin
            r_pick_q <= r_pick[r_round[PW-1:0]];
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_o_valid)
        else $error("request taken while a result is pending");

    a_wait_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWAIT) |-> r_o_valid)
        else $error("waiting for a beat that was never loaded");

    a_compact_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_wptr <= r_scan))
        else $error("compaction write overtook read");

    a_prune_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EIDX) |-> (r_removed <= r_budget))
        else $error("more events pruned than sent");

endmodule

// ===== sim/tb_gepq_ifs_note.sv =====
`timescale 1ns / 100ps
// Shared testbench types for the gossip event queue bench.
package tb_gepq_pkg;
    import gepq_pkg::*;

    typedef struct packed {
        logic [RC_W-1:0]   code;
        logic              has;
        logic [31:0]       node;
        logic [ST_W-1:0]   st;
        logic [INC_W-1:0]  inc;
        logic              last;
        logic [LEFT_W-1:0] left;
    } gepq_rsp_t;
endpackage

// ===== sim/tb_gossip_event_priority_queue.sv =====
`timescale 1ns / 100ps
// Self-checking bench: directed and random enqueue/pack traffic against a table model.
module tb_gossip_event_priority_queue;
    import gepq_pkg::*;
    import tb_gepq_pkg::*;

    localparam int DEPTH    = 64;
    localparam int PACK_MAX = 16;
    localparam int WDOG     = 20000;

    class gossip_table_sb;
        logic [31:0]      t_node[DEPTH];
        logic [ST_W-1:0]  t_st[DEPTH];
        logic [INC_W-1:0] t_inc[DEPTH];
        int unsigned      t_cnt[DEPTH];
        int unsigned      t_mult[DEPTH];
        int               used;
        gepq_rsp_t        pending[$];
        int               errors;
        int               beats;

        function automatic int unsigned pr(logic [ST_W-1:0] s);
            return (s == ST_DEAD) ? 0 : (s == ST_SUSPECT) ? 1 : 2;
        endfunction

        function automatic bit ahead(int a, int b);
            if (pr(t_st[a]) != pr(t_st[b])) return pr(t_st[a]) < pr(t_st[b]);
            if (t_cnt[a] != t_cnt[b]) return t_cnt[a] < t_cnt[b];
            return t_node[a] < t_node[b];
        endfunction

        function automatic void swap(int a, int b);
            logic [31:0] n; logic [ST_W-1:0] s; logic [INC_W-1:0] c; int unsigned k, m;
            n = t_node[a]; s = t_st[a]; c = t_inc[a]; k = t_cnt[a]; m = t_mult[a];
            t_node[a] = t_node[b]; t_st[a] = t_st[b]; t_inc[a] = t_inc[b];
            t_cnt[a] = t_cnt[b]; t_mult[a] = t_mult[b];
            t_node[b] = n; t_st[b] = s; t_inc[b] = c; t_cnt[b] = k; t_mult[b] = m;
        endfunction

        function automatic void push(logic [RC_W-1:0] code, logic has, logic [31:0] n,
                                     logic [ST_W-1:0] s, logic [INC_W-1:0] c, logic last);
            gepq_rsp_t r;
            r = '{code, has, n, s, c, last, used[LEFT_W-1:0]};
            pending.push_back(r);
        endfunction

        function automatic logic [RC_W-1:0] enqueue(logic [31:0] n, logic [ST_W-1:0] s0,
                                                     logic [INC_W-1:0] c, logic [7:0] m);
            logic [ST_W-1:0] s;
            int f;
            s = (s0 == 2'd3) ? ST_ALIVE : s0;
            f = -1;
            if (m == 0) return RC_INVALID;
            for (int i = 0; i < used; i++)
                if (f < 0 && t_node[i] == n) f = i;
            if (f < 0) begin
                if (used >= DEPTH) return RC_FULL;
                t_node[used] = n; t_st[used] = s; t_inc[used] = c;
                t_cnt[used] = 0; t_mult[used] = m;
                used++;
            end else if (c > t_inc[f]) begin
                t_st[f] = s; t_inc[f] = c; t_cnt[f] = 0; t_mult[f] = m;
            end else if (c == t_inc[f] && pr(s) < pr(t_st[f])) begin
                t_st[f] = s; t_cnt[f] = 0;
                if (m > t_mult[f]) t_mult[f] = m;
            end
            return RC_OK;
        endfunction

        function automatic void note_request(logic op, logic [31:0] n, logic [ST_W-1:0] s,
                                             logic [INC_W-1:0] c, logic [7:0] m,
                                             logic [31:0] size, logic [4:0] bud);
            int b, w, v;
            longint unsigned lim;
            bit keep[DEPTH];
            logic [31:0] rn[PACK_MAX]; logic [ST_W-1:0] rs[PACK_MAX];
            logic [INC_W-1:0] ri[PACK_MAX];
            if (op == OP_ENQUEUE) begin
                logic [RC_W-1:0] rc;
                rc = enqueue(n, s, c, m);
                push(rc, 1'b0, '0, '0, '0, 1'b1);
                return;
            end
            b = (bud > PACK_MAX) ? PACK_MAX : bud;
            if (used == 0 || b == 0) begin
                push(RC_OK, 1'b0, '0, '0, '0, 1'b1);
                return;
            end
            for (int i = 1; i < used; i++)
                for (int j = i; j > 0 && ahead(j, j - 1); j--) swap(j, j - 1);
            if (size == 0) lim = 1;
            else begin
                v = 0;
                while (v < 63 && (64'd1 << v) < ({32'd0, size} + 64'd1)) v++;
                lim = 3 * v;
            end
            if (b > used) b = used;
            for (int i = 0; i < used; i++) keep[i] = 1;
            for (int i = 0; i < b; i++) begin
                if (t_cnt[i] < 65535) t_cnt[i]++;
                keep[i] = t_cnt[i] < lim * t_mult[i];
                rn[i] = t_node[i]; rs[i] = t_st[i]; ri[i] = t_inc[i];
            end
            w = 0;
            for (int i = 0; i < used; i++)
                if (keep[i]) begin
                    t_node[w] = t_node[i]; t_st[w] = t_st[i]; t_inc[w] = t_inc[i];
                    t_cnt[w] = t_cnt[i]; t_mult[w] = t_mult[i];
                    w++;
                end
            used = w;
            for (int i = 0; i < b; i++) push(RC_OK, 1'b1, rn[i], rs[i], ri[i], i + 1 == b);
        endfunction

        task automatic check_result(gepq_rsp_t got);
            gepq_rsp_t e;
            beats++;
            if (pending.size() == 0) begin
                report("unexpected beat", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.code != e.code) report("result_code", got.code, e.code);
            if (got.has != e.has) report("has_event", got.has, e.has);
            if (got.node != e.node) report("event_node", got.node, e.node);
            if (got.st != e.st) report("event_status", got.st, e.st);
            if (got.inc != e.inc) report("event_incarnation", got.inc, e.inc);
            if (got.last != e.last) report("is_last", got.last, e.last);
            if (got.left != e.left) report("entries_left", got.left, e.left);
        endtask

        task automatic report(string what, logic [63:0] got, logic [63:0] exp);
            errors++;
            $display("mismatch at %0t: %s got %0h exp %0h", $realtime, what, got, exp);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    gepq_req_if #(.ID_W(32)) req_if ();
    gepq_rsp_if #(.ID_W(32)) rsp_if ();

    gossip_event_priority_queue #(.TABLE_DEPTH(DEPTH), .MAX_PACKED(PACK_MAX), .ID_BITS(32))
        u_top (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source));

    gossip_table_sb sb;
    int  idle_cycles;
    int  n_sent;
    int  n_packs;
    bit  hold_off;
    logic [31:0] ids[$];

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic send(logic op, logic [31:0] n, logic [ST_W-1:0] s, logic [INC_W-1:0] c,
                        logic [7:0] m, logic [31:0] size, logic [4:0] bud);
        req_if.valid        <= 1;
        req_if.operation    <= op;
        req_if.node_id      <= n;
        req_if.status       <= s;
        req_if.incarnation  <= c;
        req_if.multiplier   <= m;
        req_if.group_size   <= size;
        req_if.slot_budget  <= bud;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, n, s, c, m, size, bud);
        n_sent++;
        if (op == OP_PACK) n_packs++;
    endtask

    task automatic gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (g > 0) begin
            req_if.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic enq(logic [31:0] n, logic [ST_W-1:0] s, logic [INC_W-1:0] c, logic [7:0] m);
        send(OP_ENQUEUE, n, s, c, m, $urandom, 5'($urandom));
    endtask

    task automatic pack(logic [31:0] size, logic [4:0] bud);
        send(OP_PACK, $urandom, 2'($urandom), {$urandom, $urandom}, 8'($urandom), size, bud);
    endtask

    task automatic random_item();
        logic [31:0] n;
        int k;
        k = $urandom_range(0, 99);
        n = (ids.size() > 0 && $urandom_range(0, 2) != 0) ? ids[$urandom_range(0, ids.size() - 1)]
                                                          : $urandom;
        if (ids.size() < 80) ids.push_back(n);
        if (k < 60)
            enq(n, 2'($urandom_range(0, 3)),
                ($urandom_range(0, 1)) ? {$urandom, $urandom} : 64'($urandom_range(0, 3)),
                ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3)));
        else
            pack(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8),
                 5'($urandom_range(0, 31)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) rsp_if.ready <= 0;
        else rsp_if.ready <= ($urandom_range(0, 5) != 0) || (n_sent % 50 < 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result('{rsp_if.result_code, rsp_if.has_event, rsp_if.event_node,
                              rsp_if.event_status, rsp_if.event_incarnation,
                              rsp_if.is_last, rsp_if.entries_left});
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("watchdog expired, %0d beats outstanding", sb.pending.size());
            $display("gossip_event_priority_queue regression: fail");
            $finish;
        end
    end

    initial begin
        #0;
        wait (n_sent == 120);
        hold_off = 1;
        repeat (3000) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        sb = new();
        n_sent = 0; n_packs = 0;
        i_rst_n = 0;
        req_if.valid = 0; req_if.operation = 0; req_if.node_id = 0; req_if.status = 0;
        req_if.incarnation = 0; req_if.multiplier = 0; req_if.group_size = 0;
        req_if.slot_budget = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        pack(32'd5, 5'd4);
        enq(32'h0, ST_ALIVE, 64'd0, 8'd1);
        enq(32'hFFFF_FFFF, ST_DEAD, '1, 8'hFF);
        enq(32'h5, ST_SUSPECT, 64'd7, 8'd0);
        enq(32'h5, 2'd3, 64'd7, 8'd2);
        enq(32'h5, ST_SUSPECT, 64'd7, 8'd1);
        enq(32'h5, ST_ALIVE, 64'd7, 8'd9);
        enq(32'h5, ST_DEAD, 64'd6, 8'd9);
        enq(32'h5, ST_ALIVE, 64'd8, 8'd1);
        enq(32'hA5A5_5A5A, ST_SUSPECT, 64'h5A5A_A5A5_0F0F_F0F0, 8'd3);
        pack(32'd0, 5'd31);
        pack(32'hFFFF_FFFF, 5'd0);
        pack(32'hFFFF_FFFF, 5'd16);
        pack(32'h1, 5'd2);
        for (int i = 0; i < 70; i++) begin
            enq(32'h1000 + i, 2'(i % 3), 64'(i), 8'd1);
            gap();
        end
        pack(32'd0, 5'd16);
        pack(32'd0, 5'd16);
        repeat (4) pack(32'd0, 5'd16);

        for (int i = 0; i < 180; i++) begin
            random_item();
            gap();
        end
        req_if.valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d requests (%0d packs), %0d result beats checked",
                 n_sent, n_packs, sb.beats);
        $display("including a full table, a long receiver hold-off and saturated budgets");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("gossip_event_priority_queue regression: pass");
        else
            $display("gossip_event_priority_queue regression: fail");
        $finish;
    end
endmodule
